// ===== hw/rtl/tabx_pkg.sv =====
// ----------------------------------------------------------------------------
// tabx_pkg
// Shared types and constants of the tab expander.
// ----------------------------------------------------------------------------
`default_nettype none

package tabx_pkg;

	localparam int MAX_STOPS = 16;
	localparam int GAP_MAX   = 64;
	localparam int QDEPTH    = 4;
	localparam int QAW       = $clog2(QDEPTH);

	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] CH_SPACE = 8'd32;

	localparam logic [1:0] REG_STOP_COUNT = 2'd0;
	localparam logic [1:0] REG_GAPS_LOW   = 2'd1;
	localparam logic [1:0] REG_GAPS_HIGH  = 2'd2;

	localparam logic [4:0]  RST_STOP_COUNT = 5'd1;
	localparam logic [63:0] RST_GAPS_LOW   = 64'd8;
	localparam logic [63:0] RST_GAPS_HIGH  = 64'd0;

	// one queued job: a byte and how many copies minus one to emit
	typedef struct packed {
		logic [7:0] ch;
		logic [5:0] cnt_m1;
	} tabx_entry_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tab_expander_unit.sv =====
// ----------------------------------------------------------------------------
// tab_expander_unit
// Tab expansion against a list of tab stops, one byte per item.
//
// Input stream s_*: one text byte per item in s_tdata. Output stream m_*:
// one byte per item, m_tlast marks the final byte caused by an input item.
// A tab becomes up to 64 spaces; every other byte passes through once.
// Configuration: cfg_we writes cfg_wdata to register cfg_index (0 stop
// count, 1 gaps of stops 0..7, 2 gaps of stops 8..15); the user must
// write only while idle; the block does not enforce it. Bytes pass the
// job queue, then the output register, to m_*. Throughput: one input item
// per cycle while the queue is not full; a tab holds the output until
// all its spaces are sent. A four-entry job queue lets input continue
// while the output drains; s_tready drops only when that queue is full.
// When the receiver stalls, the current output item holds and the queue
// fills. Reset clears the queue, the line state (column, stop index) and
// loads the default configuration: one repeating stop every 8 columns.
// ----------------------------------------------------------------------------
`default_nettype none

module tab_expander_unit import tabx_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // [7:0] in_char
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]  m_tdata,        // [7:0] out_char
	output logic             m_tlast,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_wdata
);

	tabx_entry_t wr_job;
	tabx_entry_t rd_job;
	logic        full;
	logic        nonempty;
	logic        pop;
	logic        take;

	assign s_tready = !full;
	assign take     = s_tvalid && !full;

	tabx_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.take      (take),
		.in_char   (s_tdata),
		.job       (wr_job)
	);

	tabx_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (take),
		.wr_job   (wr_job),
		.full     (full),
		.pop      (pop),
		.nonempty (nonempty),
		.rd_job   (rd_job)
	);

	tabx_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.nonempty (nonempty),
		.rd_job   (rd_job),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/tabx_front.sv =====
// ----------------------------------------------------------------------------
// tabx_front
// Holds configuration and line state; turns each input item into a job.
// ----------------------------------------------------------------------------
`default_nettype none

module tabx_front import tabx_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [63:0] cfg_wdata,
	input  wire logic        take,
	input  wire logic [7:0]  in_char,
	output tabx_entry_t      job
);

	logic [4:0]  stop_count_q;
	logic [63:0] gaps_low_q;
	logic [63:0] gaps_high_q;
	logic [7:0]  column_q;
	logic [4:0]  stop_index_q;

	logic [4:0] count;
	logic       multi;
	logic [4:0] idx;
	logic       beyond;
	logic [7:0] gbyte;
	logic [6:0] gclamp;
	logic [6:0] gap;
	logic       room;
	logic [7:0] diff;
	logic       at_stop;
	logic [7:0] column_d;
	logic [4:0] stop_index_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stop_count_q <= RST_STOP_COUNT;
			gaps_low_q   <= RST_GAPS_LOW;
			gaps_high_q  <= RST_GAPS_HIGH;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_STOP_COUNT: stop_count_q <= cfg_wdata[4:0];
				REG_GAPS_LOW:   gaps_low_q   <= cfg_wdata;
				REG_GAPS_HIGH:  gaps_high_q  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		if (stop_count_q == 5'd0)
			count = 5'd1;
		else if (stop_count_q > 5'(MAX_STOPS))
			count = 5'(MAX_STOPS);
		else
			count = stop_count_q;
		multi  = count > 5'd1;
		idx    = multi ? stop_index_q : 5'd0;
		beyond = multi && (idx >= count);
		gbyte  = idx[3] ? gaps_high_q[{idx[2:0], 3'b000} +: 8]
		                : gaps_low_q[{idx[2:0], 3'b000} +: 8];
		if (gbyte == 8'd0)
			gclamp = 7'd1;
		else if (gbyte > 8'(GAP_MAX))
			gclamp = 7'(GAP_MAX);
		else
			gclamp = gbyte[6:0];
		gap     = beyond ? 7'd0 : gclamp;
		room    = !beyond && (({1'b0, column_q} + 9'd1) < {2'b00, gap});
		diff    = {1'b0, gap} - column_q - 8'd1;
		at_stop = !beyond && (column_q == ({1'b0, gap} - 8'd1));

		job.ch     = in_char;
		job.cnt_m1 = 6'd0;
		column_d     = column_q;
		stop_index_d = stop_index_q;
		if (in_char == CH_TAB) begin
			job.ch = CH_SPACE;
			if (room)
				job.cnt_m1 = diff[5:0];
			if (multi && !beyond)
				stop_index_d = idx + 5'd1;
			column_d = 8'd0;
		end else if (in_char == CH_NL) begin
			column_d     = 8'd0;
			stop_index_d = 5'd0;
		end else if (at_stop) begin
			column_d = 8'd0;
			if (multi)
				stop_index_d = idx + 5'd1;
		end else begin
			column_d = column_q + 8'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_q     <= 8'd0;
			stop_index_q <= 5'd0;
		end else if (take) begin
			column_q     <= column_d;
			stop_index_q <= stop_index_d;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tabx_queue.sv =====
// ----------------------------------------------------------------------------
// tabx_queue
// Short job queue between the classifier and the emitter.
// ----------------------------------------------------------------------------
`default_nettype none

module tabx_queue import tabx_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire tabx_entry_t wr_job,
	output logic             full,
	input  wire logic        pop,
	output logic             nonempty,
	output tabx_entry_t      rd_job
);

	tabx_entry_t       mem [QDEPTH];
	logic [QAW-1:0]    wr_ptr_q;
	logic [QAW-1:0]    rd_ptr_q;
	logic [QAW:0]      fill_q;

	assign full     = fill_q == (QAW+1)'(QDEPTH);
	assign nonempty = fill_q != '0;
	assign rd_job   = mem[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_ptr_q] <= wr_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				fill_q <= fill_q + 1'b1;
			else if (pop && !push)
				fill_q <= fill_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/tabx_back.sv =====
// ----------------------------------------------------------------------------
// tabx_back
// Emitter: repeats each queued byte the given number of times.
// ----------------------------------------------------------------------------
`default_nettype none

module tabx_back import tabx_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        nonempty,
	input  wire tabx_entry_t rd_job,
	output logic             pop,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [7:0]       m_tdata,
	output logic             m_tlast
);

	logic       valid_q;
	logic [7:0] char_q;
	logic [5:0] rem_q;
	logic       done;

	assign done     = m_tready && (rem_q == 6'd0);
	assign pop      = nonempty && (!valid_q || done);
	assign m_tvalid = valid_q;
	assign m_tdata  = char_q;
	assign m_tlast  = rem_q == 6'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rem_q   <= 6'd0;
		end else if (pop) begin
			valid_q <= 1'b1;
			rem_q   <= rd_job.cnt_m1;
		end else if (valid_q && m_tready) begin
			if (rem_q == 6'd0)
				valid_q <= 1'b0;
			else
				rem_q <= rem_q - 6'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop)
			char_q <= rd_job.ch;
	end

endmodule

`default_nettype wire
